// ===== rtl/core/ring_mailbox_node_defines.svh =====
// Assertion macros shared by the ring mailbox node RTL
`ifndef RING_MAILBOX_NODE_DEFINES_SVH
`define RING_MAILBOX_NODE_DEFINES_SVH

// check cons in the same cycle whenever ante holds
`define RMN_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ring mailbox node assertion failed");

// check cons in the cycle after ante holds
`define RMN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ring mailbox node assertion failed");

`endif

// ===== rtl/core/rmn_pkg.sv =====
// Shared types and constants of the ring mailbox node
package rmn_pkg;

   localparam int STACK_DEPTH_DEF = 8;
   localparam int WORD_W          = 8;
   localparam int RND_W           = 16;
   localparam int MOD_W           = 4;
   localparam int CNT_W           = $clog2(RND_W);
   localparam int CSR_IDX_W       = 2;
   localparam int REQ_DATA_W      = 32;
   localparam int RSP_DATA_W      = 24;

   localparam logic [WORD_W-1:0] EMPTY_WORD    = '0;
   localparam logic [WORD_W-1:0] NODE_ID_RESET = 8'd1;
   localparam logic [MOD_W-1:0]  RESTART_RESET = 4'd10;
   localparam logic [MOD_W-1:0]  RESTART_MIN   = 4'd2;
   localparam logic [MOD_W-1:0]  ALERT_RESET   = 4'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_ID = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTART = 2'd1;

   typedef struct packed {
      logic             done;
      logic [MOD_W-1:0] remainder;
   } mod_status_type;

   // packed from the top down: write_valid lands in bit 0
   typedef struct packed {
      logic [3:0]        pending_count;
      logic              dropped;
      logic              own_returned;
      logic [WORD_W-1:0] received_from;
      logic              upstream_clear;
      logic [WORD_W-1:0] write_word;
      logic              write_valid;
   } rsp_type;

endpackage

// ===== rtl/core/rmn_stack.sv =====
// Pending-word stack memory: one write port, one registered read port
module rmn_stack #(
   parameter int STACK_DEPTH = rmn_pkg::STACK_DEPTH_DEF,
   parameter int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [rmn_pkg::WORD_W-1:0] wr_data,
   input  logic [AW-1:0]             rd_addr,
   output logic [rmn_pkg::WORD_W-1:0] rd_data
);

   logic [rmn_pkg::WORD_W-1:0] mem [STACK_DEPTH];
   logic [rmn_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rmn_mod_unit.sv =====
// Bit-serial remainder unit: random word modulo a small countdown value
module rmn_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rmn_pkg::RND_W-1:0]   dividend,
   input  logic [rmn_pkg::MOD_W-1:0]   divisor,
   output rmn_pkg::mod_status_type     status
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [rmn_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [rmn_pkg::MOD_W-1:0]  rem_ff, rem_in;
   logic [rmn_pkg::MOD_W-1:0]  div_ff, div_in;
   logic [rmn_pkg::RND_W-1:0]  bits_ff, bits_in;
   logic [rmn_pkg::MOD_W:0]    shifted;
   logic [rmn_pkg::MOD_W:0]    diff;

   assign shifted = {rem_ff, bits_ff[rmn_pkg::RND_W-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      bits_in = bits_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
         bits_in = dividend;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         bits_in = {bits_ff[rmn_pkg::RND_W-2:0], 1'b0};
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = diff[rmn_pkg::MOD_W-1:0];
         end else begin
            rem_in = shifted[rmn_pkg::MOD_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rmn_pkg::CNT_W'(rmn_pkg::RND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      bits_ff <= bits_in;
   end

   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

// ===== rtl/core/ring_mailbox_node.sv =====
// Ring mailbox node top level: tick sequencer, state and result register
//
// One ring stop. Each request beat is one tick: upstream mailbox word, downstream-free
// flag and a random word. Each tick yields exactly one response beat with the word
// written downstream, the upstream clear, the foreign id passed on, the own-return and
// drop flags and the pending stack depth.
// csr_ writes set node_id (index 0) and restart_modulus (index 1); csr_ready is always
// high, other indexes are ignored. Write only while no tick is in progress.
// A tick runs from the request beat through the tick decisions, two stack write
// slots (the second also starts the remainder unit), the bit-serial remainder unit
// (16 steps and its done flag), then the load of the response register, which sets
// response valid. req_tready is high only between ticks, so the next request beat
// is taken at the earliest in the same cycle in which response valid rises: a new
// request beat is not taken before the tick in progress has loaded its response.
// Reset clears the stack depth, the in-flight flag, reloads the countdown to 10 and
// the alert to 1, and sets node_id to 1 and restart_modulus to 10.
// A stalled response holds its beat; a new request beat is still taken while it
// waits, and that tick finishes once the held beat is gone.
`include "ring_mailbox_node_defines.svh"

module ring_mailbox_node #(
   parameter int STACK_DEPTH = rmn_pkg::STACK_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: upstream_word[7:0], downstream_free[8], random_word[24:9], zero fill
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rmn_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tdata: write_valid[0], write_word[8:1], upstream_clear[9], received_from[17:10],
   //        own_returned[18], dropped[19], pending_count[23:20]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rmn_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rmn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rmn_pkg::WORD_W-1:0]        csr_wdata
);

   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [DW-1:0] FULL_DEPTH = DW'(STACK_DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CALC   = 6'b000010,
      ST_PUSH_A = 6'b000100,
      ST_PUSH_B = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;

   logic [rmn_pkg::WORD_W-1:0]    node_id_ff;
   logic [rmn_pkg::MOD_W-1:0]     restart_ff;
   logic [DW-1:0]                 depth_ff, depth_in;
   logic                          in_flight_ff, in_flight_in;
   logic [rmn_pkg::MOD_W-1:0]     cm_ff, cm_in;
   logic [rmn_pkg::MOD_W-1:0]     alert_ff, alert_in;

   logic [rmn_pkg::WORD_W-1:0]    up_ff;
   logic                          free_ff;
   logic [rmn_pkg::RND_W-1:0]     rnd_ff;

   logic                          pa_we_ff, pa_we_in;
   logic [AW-1:0]                 pa_addr_ff, pa_addr_in;
   logic [rmn_pkg::WORD_W-1:0]    pa_data_ff, pa_data_in;
   logic                          pb_we_ff, pb_we_in;
   logic [AW-1:0]                 pb_addr_ff, pb_addr_in;
   logic [rmn_pkg::WORD_W-1:0]    pb_data_ff, pb_data_in;

   rmn_pkg::rsp_type              tick_ff, tick_in;
   rmn_pkg::rsp_type              rsp_ff;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic [rmn_pkg::MOD_W-1:0]     restart_val;
   logic [DW-1:0]                 depth_dec;
   logic [AW-1:0]                 rd_addr;
   logic [rmn_pkg::WORD_W-1:0]    top_word;
   logic                          st_we;
   logic [AW-1:0]                 st_addr;
   logic [rmn_pkg::WORD_W-1:0]    st_data;
   logic                          mod_start;
   rmn_pkg::mod_status_type       mod_status;
   logic                          req_fire;
   logic                          rsp_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign restart_val = (restart_ff < rmn_pkg::RESTART_MIN) ? rmn_pkg::RESTART_MIN
                                                            : restart_ff;
   assign depth_dec = depth_ff - 1'b1;
   assign rd_addr   = (depth_ff == '0) ? '0 : depth_dec[AW-1:0];

   assign st_we   = (state_ff == ST_PUSH_A) ? pa_we_ff :
                    (state_ff == ST_PUSH_B) ? pb_we_ff : 1'b0;
   assign st_addr = (state_ff == ST_PUSH_B) ? pb_addr_ff : pa_addr_ff;
   assign st_data = (state_ff == ST_PUSH_B) ? pb_data_ff : pa_data_ff;
   assign mod_start = (state_ff == ST_PUSH_B);

   rmn_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_addr),
      .wr_data (st_data),
      .rd_addr (rd_addr),
      .rd_data (top_word)
   );

   rmn_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (rnd_ff),
      .divisor  (cm_ff),
      .status   (mod_status)
   );

   // tick decisions: resend, own send, restart, upstream
   always_comb begin
      logic                       free1;
      logic                       free2;
      logic                       own_send;
      logic [DW-1:0]              d1;
      logic [DW-1:0]              d2;
      logic [DW-1:0]              d3;
      logic [rmn_pkg::MOD_W-1:0]  cm1;
      d1       = depth_ff;
      free1    = free_ff;
      own_send = (alert_ff == '0) && !in_flight_ff;
      tick_in  = '0;
      pa_we_in   = 1'b0;
      pa_addr_in = d1[AW-1:0];
      pa_data_in = node_id_ff;
      pb_we_in   = 1'b0;
      pb_addr_in = d1[AW-1:0];
      pb_data_in = up_ff;
      in_flight_in = in_flight_ff;

      if ((depth_ff != '0) && free_ff) begin
         d1    = depth_dec;
         free1 = 1'b0;
         tick_in.write_valid = 1'b1;
         tick_in.write_word  = top_word;
      end

      d2    = d1;
      free2 = free1;
      cm1   = cm_ff;
      pa_addr_in = d1[AW-1:0];
      if (own_send) begin
         in_flight_in = 1'b1;
         cm1 = restart_val;
         if (free1) begin
            free2 = 1'b0;
            tick_in.write_valid = 1'b1;
            tick_in.write_word  = node_id_ff;
         end else if (d1 < FULL_DEPTH) begin
            pa_we_in = 1'b1;
            d2 = d1 + 1'b1;
         end else begin
            tick_in.dropped = 1'b1;
         end
      end

      if (cm1 <= 4'd1) begin
         cm1 = restart_val;
      end

      d3 = d2;
      pb_addr_in = d2[AW-1:0];
      if (up_ff != rmn_pkg::EMPTY_WORD) begin
         tick_in.upstream_clear = 1'b1;
         if (up_ff != node_id_ff) begin
            tick_in.received_from = up_ff;
            if (free2) begin
               tick_in.write_valid = 1'b1;
               tick_in.write_word  = up_ff;
            end else if (d2 < FULL_DEPTH) begin
               pb_we_in = 1'b1;
               d3 = d2 + 1'b1;
            end else begin
               tick_in.dropped = 1'b1;
            end
         end else begin
            in_flight_in = 1'b0;
            tick_in.own_returned = 1'b1;
         end
      end

      depth_in = d3;
      cm_in    = cm1 - 1'b1;
      tick_in.pending_count = 4'(d3);
   end

   always_comb begin
      state_in     = state_ff;
      alert_in     = alert_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC:   state_in = ST_PUSH_A;
         ST_PUSH_A: state_in = ST_PUSH_B;
         ST_PUSH_B: state_in = ST_DIV;
         ST_DIV: begin
            if (mod_status.done) begin
               alert_in = mod_status.remainder;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         node_id_ff   <= rmn_pkg::NODE_ID_RESET;
         restart_ff   <= rmn_pkg::RESTART_RESET;
         depth_ff     <= '0;
         in_flight_ff <= 1'b0;
         cm_ff        <= rmn_pkg::RESTART_RESET;
         alert_ff     <= rmn_pkg::ALERT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alert_ff     <= alert_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CALC) begin
            depth_ff     <= depth_in;
            in_flight_ff <= in_flight_in;
            cm_ff        <= cm_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rmn_pkg::CSR_NODE_ID: node_id_ff <= csr_wdata;
               rmn_pkg::CSR_RESTART: restart_ff <= csr_wdata[rmn_pkg::MOD_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         up_ff   <= req_tdata[7:0];
         free_ff <= req_tdata[8];
         rnd_ff  <= req_tdata[24:9];
      end
      if (state_ff == ST_CALC) begin
         tick_ff    <= tick_in;
         pa_we_ff   <= pa_we_in;
         pa_addr_ff <= pa_addr_in;
         pa_data_ff <= pa_data_in;
         pb_we_ff   <= pb_we_in;
         pb_addr_ff <= pb_addr_in;
         pb_data_ff <= pb_data_in;
      end
      if (rsp_load) begin
         rsp_ff <= tick_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   `RMN_ASSERT_SAME(a_depth_bound, clock, reset, 1'b1, depth_ff <= FULL_DEPTH)
   `RMN_ASSERT_SAME(a_own_or_foreign, clock, reset, tick_ff.own_returned,
                    tick_ff.received_from == rmn_pkg::EMPTY_WORD)
   `RMN_ASSERT_SAME(a_done_in_div, clock, reset, mod_status.done, state_ff == ST_DIV)
   `RMN_ASSERT_NEXT(a_drop_full, clock, reset, (state_ff == ST_CALC) && tick_in.dropped,
                    depth_ff == FULL_DEPTH)

endmodule
